>>> rtl/vfr_pkg.sv
// ----------------------------------------------------------------------------
// vfr_pkg
// Shared sizes, verdict codes and the bitmap control bundle of the video
// fragment reassembler.
// ----------------------------------------------------------------------------
package vfr_pkg;

	localparam int MAX_PIECES  = 256;
	localparam int PIECE_BYTES = 1024;

	localparam int FRAME_W  = 32;
	localparam int INDEX_W  = 8;
	localparam int TOTAL_W  = 9;
	localparam int LENGTH_W = 11;
	localparam int OFFSET_W = 18;
	localparam int SIZE_W   = 19;
	localparam int SEEN_W   = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;

	localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

	typedef enum logic [2:0] {
		V_STORED   = 3'd0,
		V_COMPLETE = 3'd1,
		V_LATE     = 3'd2,
		V_DUP      = 3'd3,
		V_RANGE    = 3'd4
	} verdict_t;

	typedef struct packed {
		logic              clear;
		logic              set;
		logic [SEEN_W-1:0] idx;
	} seen_ctrl_t;

endpackage

>>> rtl/vfr_bitmap.sv
// ----------------------------------------------------------------------------
// vfr_bitmap
// Received-fragment bitmap: one flip-flop per fragment slot, cleared as a
// whole when a frame opens or completes, set one slot per stored beat.
// ----------------------------------------------------------------------------
module vfr_bitmap
	import vfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  seen_ctrl_t        ctrl,
	input  logic [SEEN_W-1:0] rd_idx,
	output logic              rd_bit
);

	logic [MAX_PIECES-1:0] seen_q;
	logic [MAX_PIECES-1:0] seen_next;

	always_comb begin
		seen_next = ctrl.clear ? '0 : seen_q;
		if (ctrl.set) begin
			seen_next[ctrl.idx] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (ctrl.clear || ctrl.set) begin
			seen_q <= seen_next;
		end
	end

	assign rd_bit = seen_q[rd_idx];

endmodule

>>> rtl/vfr_core.sv
// ----------------------------------------------------------------------------
// vfr_core
// Open-frame state and the per-fragment decision: late, abandon, open,
// range and duplicate checks, storage offset, final size and completion.
// ----------------------------------------------------------------------------
module vfr_core
	import vfr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [FRAME_W-1:0]  frame_number,
	input  logic [INDEX_W-1:0]  piece_index,
	input  logic [TOTAL_W-1:0]  piece_total,
	input  logic                is_keyframe,
	input  logic                is_final_piece,
	input  logic [LENGTH_W-1:0] payload_length,
	output verdict_t            verdict,
	output logic [OFFSET_W-1:0] write_offset,
	output logic [SIZE_W-1:0]   frame_bytes,
	output logic                frame_was_keyframe,
	output logic                abandoned_frame,
	output logic [TOTAL_W-1:0]  abandoned_missing
);

	logic [FRAME_W-1:0] ofn_q;
	logic [TOTAL_W-1:0] exp_q;
	logic [TOTAL_W-1:0] held_q;
	logic               key_q;
	logic [SIZE_W-1:0]  size_q;

	logic               late;
	logic               drop;
	logic               open;
	logic [TOTAL_W-1:0] eff_exp;
	logic [TOTAL_W-1:0] eff_held;
	logic [SIZE_W-1:0]  eff_size;
	logic               eff_key;
	logic               eff_seen;
	logic               seen_bit;
	logic               in_range;
	logic               store;
	logic               complete;
	logic [31:0]        off_full;
	logic [31:0]        size_sum;
	logic [SIZE_W-1:0]  new_size;
	logic [TOTAL_W-1:0] held_inc;
	seen_ctrl_t         seen_ctrl;

	vfr_bitmap u_bitmap (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (seen_ctrl),
		.rd_idx (SEEN_W'(piece_index)),
		.rd_bit (seen_bit)
	);

	always_comb begin
		late     = (frame_number < ofn_q) && (ofn_q != '0);
		drop     = !late && (frame_number > ofn_q) && (exp_q != '0);
		open     = !late && ((frame_number != ofn_q) || (exp_q == '0));
		eff_exp  = open ? piece_total : exp_q;
		eff_held = open ? '0 : held_q;
		eff_size = open ? '0 : size_q;
		eff_key  = open ? is_keyframe : key_q;
		eff_seen = !open && seen_bit;
		in_range = ({1'b0, piece_index} < eff_exp) && (32'(piece_index) < MAX_PIECES);
		store    = !late && in_range && !eff_seen;
		off_full = 32'(32'(piece_index) * PIECE_BYTES);
		size_sum = off_full + 32'(payload_length);
		if (is_final_piece) begin
			new_size = (size_sum > 32'(SIZE_SAT)) ? SIZE_SAT : SIZE_W'(size_sum);
		end else begin
			new_size = eff_size;
		end
		held_inc = eff_held + TOTAL_W'(1);
		complete = store && (held_inc == eff_exp) && (new_size != '0);

		priority if (late) begin
			verdict = V_LATE;
		end else if (!in_range) begin
			verdict = V_RANGE;
		end else if (eff_seen) begin
			verdict = V_DUP;
		end else if (complete) begin
			verdict = V_COMPLETE;
		end else begin
			verdict = V_STORED;
		end

		write_offset       = store ? OFFSET_W'(off_full) : '0;
		frame_bytes        = complete ? new_size : '0;
		frame_was_keyframe = complete && eff_key;
		abandoned_frame    = drop;
		abandoned_missing  = drop ? (exp_q - held_q) : '0;

		seen_ctrl.clear = fire && (open || complete);
		seen_ctrl.set   = fire && store && !complete;
		seen_ctrl.idx   = SEEN_W'(piece_index);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofn_q  <= '0;
			exp_q  <= '0;
			held_q <= '0;
			key_q  <= 1'b0;
			size_q <= '0;
		end else if (fire && !late) begin
			if (complete) begin
				ofn_q  <= frame_number + FRAME_W'(1);
				exp_q  <= '0;
				held_q <= '0;
				key_q  <= 1'b0;
				size_q <= '0;
			end else begin
				ofn_q  <= frame_number;
				exp_q  <= eff_exp;
				held_q <= store ? held_inc : eff_held;
				key_q  <= eff_key;
				size_q <= store ? new_size : eff_size;
			end
		end
	end

endmodule

>>> rtl/video_fragment_reassembler.sv
// ----------------------------------------------------------------------------
// video_fragment_reassembler
// Bookkeeping for reassembling video frames from fragment headers.
// ----------------------------------------------------------------------------
// Each beat on the item channel is one fragment header. Each header gives
// exactly one beat on the result channel, in order: a verdict, the byte
// offset for the payload in the frame memory, and on completion the frame
// size and keyframe mark. A header that drops an unfinished older frame
// also reports how many fragments that frame lacked.
// The header is registered on entry, evaluated against the open-frame state
// combinationally, and registered at the output. One header is taken every
// cycle while the receiver does not stall; the state update of one header is
// visible to the header taken right after it.
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more header; item_ready falls only while
// both are full. Reset clears the open-frame state and the fragment bitmap
// at once; the block takes headers from the first cycle after reset.
// ----------------------------------------------------------------------------
module video_fragment_reassembler
	import vfr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [FRAME_W-1:0]  frame_number,
	input  logic [INDEX_W-1:0]  piece_index,
	input  logic [TOTAL_W-1:0]  piece_total,
	input  logic                is_keyframe,
	input  logic                is_final_piece,
	input  logic [LENGTH_W-1:0] payload_length,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [2:0]          verdict,
	output logic [OFFSET_W-1:0] write_offset,
	output logic [SIZE_W-1:0]   frame_bytes,
	output logic                frame_was_keyframe,
	output logic                abandoned_frame,
	output logic [TOTAL_W-1:0]  abandoned_missing
);

	logic                valid_s1;
	logic [FRAME_W-1:0]  frame_number_s1;
	logic [INDEX_W-1:0]  piece_index_s1;
	logic [TOTAL_W-1:0]  piece_total_s1;
	logic                is_keyframe_s1;
	logic                is_final_piece_s1;
	logic [LENGTH_W-1:0] payload_length_s1;

	logic                valid_s2;
	verdict_t            verdict_s2;
	logic [OFFSET_W-1:0] write_offset_s2;
	logic [SIZE_W-1:0]   frame_bytes_s2;
	logic                frame_was_keyframe_s2;
	logic                abandoned_frame_s2;
	logic [TOTAL_W-1:0]  abandoned_missing_s2;

	logic                advance;
	logic                fire;
	logic                take;
	verdict_t            core_verdict;
	logic [OFFSET_W-1:0] core_offset;
	logic [SIZE_W-1:0]   core_bytes;
	logic                core_key;
	logic                core_drop;
	logic [TOTAL_W-1:0]  core_missing;

	assign advance    = !valid_s2 || result_ready;
	assign fire       = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;
	assign take       = item_valid && item_ready;

	vfr_core u_core (
		.clk                (clk),
		.arst_n             (arst_n),
		.fire               (fire),
		.frame_number       (frame_number_s1),
		.piece_index        (piece_index_s1),
		.piece_total        (piece_total_s1),
		.is_keyframe        (is_keyframe_s1),
		.is_final_piece     (is_final_piece_s1),
		.payload_length     (payload_length_s1),
		.verdict            (core_verdict),
		.write_offset       (core_offset),
		.frame_bytes        (core_bytes),
		.frame_was_keyframe (core_key),
		.abandoned_frame    (core_drop),
		.abandoned_missing  (core_missing)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frame_number_s1   <= frame_number;
			piece_index_s1    <= piece_index;
			piece_total_s1    <= piece_total;
			is_keyframe_s1    <= is_keyframe;
			is_final_piece_s1 <= is_final_piece;
			payload_length_s1 <= payload_length;
		end
		if (fire) begin
			verdict_s2            <= core_verdict;
			write_offset_s2       <= core_offset;
			frame_bytes_s2        <= core_bytes;
			frame_was_keyframe_s2 <= core_key;
			abandoned_frame_s2    <= core_drop;
			abandoned_missing_s2  <= core_missing;
		end
	end

	assign result_valid       = valid_s2;
	assign verdict            = verdict_s2;
	assign write_offset       = write_offset_s2;
	assign frame_bytes        = frame_bytes_s2;
	assign frame_was_keyframe = frame_was_keyframe_s2;
	assign abandoned_frame    = abandoned_frame_s2;
	assign abandoned_missing  = abandoned_missing_s2;

endmodule

>>> rtl/vfr_checker.sv
// ----------------------------------------------------------------------------
// vfr_checker
// Port-level checks on the video fragment reassembler, bound to the top.
// ----------------------------------------------------------------------------
module vfr_checker
	import vfr_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input logic                result_valid,
	input logic                result_ready,
	input logic [2:0]          verdict,
	input logic [OFFSET_W-1:0] write_offset,
	input logic [SIZE_W-1:0]   frame_bytes,
	input logic                frame_was_keyframe,
	input logic                abandoned_frame,
	input logic [TOTAL_W-1:0]  abandoned_missing
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(verdict)
			&& $stable(write_offset) && $stable(frame_bytes))
		else $error("Result beat changed while stalled.");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |-> ##2 result_valid)
		else $error("No result two cycles after a header beat.");

	a_size_only_on_complete: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && verdict != V_COMPLETE |-> frame_bytes == '0 && !frame_was_keyframe)
		else $error("Frame size reported without completion.");

	a_offset_only_on_store: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (verdict == V_LATE || verdict == V_DUP || verdict == V_RANGE)
			|-> write_offset == '0)
		else $error("Offset reported for a rejected fragment.");

	a_missing_only_on_drop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (!abandoned_frame || verdict == V_LATE)
			|-> abandoned_missing == '0 && !(abandoned_frame && verdict == V_LATE))
		else $error("Abandon report inconsistent with the verdict.");

endmodule

bind video_fragment_reassembler vfr_checker u_vfr_checker (.*);

>>> sim/tb_video_fragment_reassembler.sv
// ----------------------------------------------------------------------------
// tb_video_fragment_reassembler
// Self-checking bench for the video fragment reassembler.
// ----------------------------------------------------------------------------
// A directed run covers the corner cases: zero final size, duplicates,
// indexes out of range, late fragments, abandoned frames, zero and oversized
// piece totals, and frame number wrap. After it comes a random stream of
// mostly well-formed frames with pieces shuffled, dropped, repeated or out
// of range. Every accepted header goes through a bookkeeping model held in
// the bench. Its outcome is queued, and each result beat is compared field
// by field with the oldest queued outcome. The sender works in bursts and
// the receiver stalls, with one long hold-off so that the block backs up.
// ----------------------------------------------------------------------------
module tb_video_fragment_reassembler;
	import vfr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [FRAME_W-1:0]  frame_number;
		logic [INDEX_W-1:0]  piece_index;
		logic [TOTAL_W-1:0]  piece_total;
		logic                is_keyframe;
		logic                is_final_piece;
		logic [LENGTH_W-1:0] payload_length;
	} frag_hdr_t;

	typedef struct packed {
		verdict_t            verdict;
		logic [OFFSET_W-1:0] write_offset;
		logic [SIZE_W-1:0]   frame_bytes;
		logic                frame_was_keyframe;
		logic                abandoned_frame;
		logic [TOTAL_W-1:0]  abandoned_missing;
	} frag_outcome_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_ready;
	logic [FRAME_W-1:0]  frame_number = '0;
	logic [INDEX_W-1:0]  piece_index = '0;
	logic [TOTAL_W-1:0]  piece_total = '0;
	logic                is_keyframe = 1'b0;
	logic                is_final_piece = 1'b0;
	logic [LENGTH_W-1:0] payload_length = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic [2:0]          verdict;
	logic [OFFSET_W-1:0] write_offset;
	logic [SIZE_W-1:0]   frame_bytes;
	logic                frame_was_keyframe;
	logic                abandoned_frame;
	logic [TOTAL_W-1:0]  abandoned_missing;

	frag_hdr_t     pending_headers[$];
	frag_outcome_t awaited_outcomes[$];
	int            fault_count = 0;
	int            results_seen = 0;
	logic          hdr_taken = 1'b0;
	logic [31:0]   gen_frame = '0;

	logic [FRAME_W-1:0]    cur_frame = '0;
	logic [TOTAL_W-1:0]    pieces_wanted = '0;
	logic [TOTAL_W-1:0]    pieces_have = '0;
	logic [MAX_PIECES-1:0] have_map = '0;
	logic                  cur_key = 1'b0;
	logic [SIZE_W-1:0]     cur_size = '0;

	video_fragment_reassembler dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_open_frame();
		pieces_wanted = '0;
		pieces_have = '0;
		have_map = '0;
		cur_key = 1'b0;
		cur_size = '0;
	endfunction

	function automatic frag_outcome_t book_fragment(frag_hdr_t h);
		frag_outcome_t res;
		logic [OFFSET_W-1:0] off;
		logic [SIZE_W:0] sum;
		res = '0;
		res.verdict = V_STORED;
		if (h.frame_number < cur_frame && cur_frame != 0) begin
			res.verdict = V_LATE;
		end else begin
			if (h.frame_number > cur_frame && pieces_wanted != 0) begin
				res.abandoned_frame = 1'b1;
				res.abandoned_missing = pieces_wanted - pieces_have;
				clear_open_frame();
			end
			if (h.frame_number != cur_frame || pieces_wanted == 0) begin
				clear_open_frame();
				cur_frame = h.frame_number;
				pieces_wanted = h.piece_total;
				cur_key = h.is_keyframe;
			end
			if ({1'b0, h.piece_index} >= pieces_wanted || int'(h.piece_index) >= MAX_PIECES) begin
				res.verdict = V_RANGE;
			end else if (have_map[h.piece_index]) begin
				res.verdict = V_DUP;
			end else begin
				off = OFFSET_W'(int'(h.piece_index) * PIECE_BYTES);
				have_map[h.piece_index] = 1'b1;
				pieces_have = pieces_have + 1'b1;
				res.write_offset = off;
				if (h.is_final_piece) begin
					sum = off + h.payload_length;
					cur_size = (sum > SIZE_SAT) ? SIZE_SAT : sum[SIZE_W-1:0];
				end
				if (pieces_have == pieces_wanted && cur_size != 0) begin
					res.verdict = V_COMPLETE;
					res.frame_bytes = cur_size;
					res.frame_was_keyframe = cur_key;
					clear_open_frame();
					cur_frame = h.frame_number + 1'b1;
				end
			end
		end
		return res;
	endfunction

	task automatic queue_header(input logic [31:0] fnum, input int unsigned idx,
			input int unsigned total, input logic key, input logic fin,
			input int unsigned plen);
		frag_hdr_t h;
		h.frame_number = fnum;
		h.piece_index = idx[INDEX_W-1:0];
		h.piece_total = total[TOTAL_W-1:0];
		h.is_keyframe = key;
		h.is_final_piece = fin;
		h.payload_length = plen[LENGTH_W-1:0];
		pending_headers.push_back(h);
	endtask

	task automatic add_random_frame();
		int unsigned pick, total, span, n, idx, plen, tmp, j, k;
		logic key, fin;
		logic [31:0] fnum;
		int unsigned order[$];
		pick = $urandom_range(0, 99);
		if (pick < 70)
			fnum = gen_frame + 1;
		else if (pick < 80)
			fnum = gen_frame + $urandom_range(2, 5);
		else if (pick < 88)
			fnum = $urandom;
		else if (pick < 94)
			fnum = 32'hFFFF_FFFF - $urandom_range(0, 2);
		else
			fnum = gen_frame;
		gen_frame = fnum;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			total = $urandom_range(1, 6);
		else if (pick < 85)
			total = $urandom_range(7, 24);
		else if (pick < 90)
			total = $urandom_range(25, 256);
		else if (pick < 95)
			total = 0;
		else
			total = $urandom_range(257, 511);
		key = $urandom_range(0, 1);
		if (total > 0 && total <= 24) begin
			for (j = 0; j < total; j++)
				order.push_back(j);
			for (j = total - 1; j > 0; j--) begin
				k = $urandom_range(0, j);
				tmp = order[j];
				order[j] = order[k];
				order[k] = tmp;
			end
		end else begin
			span = (total == 0 || total > 256) ? 256 : total;
			n = $urandom_range(1, 6);
			for (j = 0; j < n; j++)
				order.push_back($urandom_range(0, span - 1));
		end
		foreach (order[j]) begin
			idx = order[j];
			if ($urandom_range(0, 99) < 6)
				continue;
			fin = (idx == total - 1) || ($urandom_range(0, 49) == 0);
			pick = $urandom_range(0, 99);
			if (fin)
				plen = (pick < 10) ? 0 : (pick < 20) ? $urandom_range(1025, 2047)
						: $urandom_range(1, 1024);
			else
				plen = (pick < 80) ? PIECE_BYTES : $urandom_range(0, 2047);
			queue_header(fnum, idx, total, key ^ ($urandom_range(0, 9) == 0), fin, plen);
			if ($urandom_range(0, 99) < 6)
				queue_header(fnum, idx, total, key, fin, plen);
			if ($urandom_range(0, 99) < 5 && total < 256)
				queue_header(fnum, $urandom_range(total, 255), total, key, 1'b0, plen);
			if ($urandom_range(0, 99) < 5)
				queue_header(fnum - $urandom_range(1, 3), $urandom_range(0, 255),
						$urandom_range(0, 511), $urandom_range(0, 1),
						$urandom_range(0, 1), $urandom_range(0, 2047));
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fault_count++;
		end
	endtask

	initial begin
		queue_header(0, 0, 1, 0, 1, 0);
		queue_header(0, 0, 1, 0, 0, 5);
		queue_header(0, 1, 1, 0, 0, 5);
		queue_header(5, 0, 2, 1, 0, 1024);
		queue_header(5, 1, 2, 0, 1, 1024);
		queue_header(3, 0, 1, 0, 1, 10);
		queue_header(6, 0, 0, 0, 0, 0);
		queue_header(6, 0, 256, 0, 0, 1024);
		queue_header(6, 255, 256, 0, 1, 2047);
		queue_header(6, 255, 256, 0, 1, 2047);
		queue_header(6, 128, 300, 1, 0, 1024);
		queue_header(32'hFFFF_FFFF, 0, 1, 1, 1, 1024);
		queue_header(0, 0, 1, 0, 1, 1);
		queue_header(0, 0, 1, 0, 1, 1);
		queue_header(7, 3, 511, 1, 0, 2047);
		queue_header(7, 0, 511, 0, 0, 1024);
		queue_header(8, 0, 1, 0, 1, 1);
		queue_header(9, 1, 1, 0, 1, 0);
		queue_header(9, 0, 1, 0, 1, 0);
		queue_header(9, 0, 1, 0, 1, 0);
		queue_header(10, 0, 2, 0, 1, 100);
		queue_header(10, 1, 2, 0, 0, 50);
		gen_frame = 10;
		while (pending_headers.size() < 470)
			add_random_frame();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_headers.size() != 0 || awaited_outcomes.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || hdr_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (pending_headers.size() == 0) begin
				item_valid <= 1'b0;
			end else begin
				item_valid <= 1'b1;
				frame_number <= pending_headers[0].frame_number;
				piece_index <= pending_headers[0].piece_index;
				piece_total <= pending_headers[0].piece_total;
				is_keyframe <= pending_headers[0].is_keyframe;
				is_final_piece <= pending_headers[0].is_final_piece;
				payload_length <= pending_headers[0].payload_length;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	int unsigned rx_cycle = 0;
	int unsigned hold_left = 0;
	logic        long_hold_done = 1'b0;

	always @(negedge clk) begin
		rx_cycle++;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			if (hold_left == 0)
				long_hold_done = 1'b1;
			result_ready <= 1'b0;
		end else if (!long_hold_done && results_seen >= 150) begin
			hold_left = 47;
			result_ready <= 1'b0;
		end else begin
			case ((rx_cycle / 97) % 4)
				0: result_ready <= 1'b1;
				1: result_ready <= ($urandom_range(0, 2) != 0);
				2: result_ready <= (rx_cycle % 5 != 0);
				default: result_ready <= $urandom_range(0, 1);
			endcase
		end
	end

	always @(posedge clk) begin
		frag_outcome_t want;
		frag_hdr_t hdr;
		if (!arst_n) begin
			hdr_taken <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				results_seen++;
				if (awaited_outcomes.size() == 0) begin
					$display("%0t ns: unexpected result beat, expected none, got verdict %0d",
							$time, verdict);
					fault_count++;
				end else begin
					want = awaited_outcomes.pop_front();
					check_field("verdict", want.verdict, verdict);
					check_field("write_offset", want.write_offset, write_offset);
					check_field("frame_bytes", want.frame_bytes, frame_bytes);
					check_field("frame_was_keyframe", want.frame_was_keyframe,
							frame_was_keyframe);
					check_field("abandoned_frame", want.abandoned_frame, abandoned_frame);
					check_field("abandoned_missing", want.abandoned_missing,
							abandoned_missing);
				end
			end
			if (item_valid && item_ready) begin
				hdr = pending_headers.pop_front();
				awaited_outcomes.push_back(book_fragment(hdr));
			end
			hdr_taken <= item_valid && item_ready;
		end
	end

endmodule

>>> sim.f
rtl/vfr_pkg.sv
rtl/vfr_bitmap.sv
rtl/vfr_core.sv
rtl/video_fragment_reassembler.sv
rtl/vfr_checker.sv
sim/tb_video_fragment_reassembler.sv
